FILE: hw/rtl/msb_pkg.sv
package msb_pkg;

  // Scaling factor and screen size
  localparam int SCALE         = 4;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  // Field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int COLOR_W = 16;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 2;

  // Internal coordinate width: holds screen size plus scaled sprite size
  localparam int PW    = 13;
  // Remaining-span counter width
  localparam int CNT_W = $clog2(SCALE + 1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = IDX_W'(1);

  // Reset values of the size registers
  localparam logic [COL_W-1:0] SRC_WIDTH_RST  = COL_W'(48);
  localparam logic [ROW_W-1:0] SRC_HEIGHT_RST = ROW_W'(48);

  // One positioned source pixel, waiting for the span emitter
  typedef struct packed {
    logic                      valid;
    logic                      opaque;
    logic signed [X_W-1:0]     x;
    logic signed [Y_W-1:0]     y;
    logic        [COLOR_W-1:0] color;
  } item_t;

  // Offset of the scaled sprite on one axis: (screen - size*SCALE)/2,
  // truncated toward zero
  function automatic logic signed [PW-1:0] centre_offset(
    input logic [PW-1:0] screen,
    input logic [PW-1:0] size
  );
    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] adj;
    diff = $signed(screen - size * PW'(SCALE));
    adj  = (diff[PW-1] && diff[0]) ? diff + PW'(1) : diff;
    return adj >>> 1;
  endfunction

endpackage

FILE: hw/rtl/msb_coord.sv
module msb_coord import msb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               frame_start,
  input  logic               opaque,
  input  logic [COLOR_W-1:0] color,
  input  logic               take,
  output item_t              item
);

  logic [COL_W-1:0] src_width;
  logic [ROW_W-1:0] src_height;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_pos_next;
  logic [ROW_W-1:0] row_pos_next;
  logic             accept;
  logic signed [PW-1:0] x0;
  logic signed [PW-1:0] y0;
  logic signed [PW-1:0] x_full;
  logic signed [PW-1:0] y_full;

  assign in_stall = item.valid && !take;
  assign accept   = in_valid && !in_stall;

  // Write the size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_RST;
      src_height <= SRC_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SRC_WIDTH:  src_width  <= wr_data;
        REG_SRC_HEIGHT: src_height <= wr_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the pixel in this transaction
  assign col_cur = frame_start ? '0 : col_pos;
  assign row_cur = frame_start ? '0 : row_pos;

  // Advance column, wrap into the next row, wrap the row at the sprite height
  always_comb begin
    col_pos_next = col_cur + COL_W'(1);
    row_pos_next = row_cur;
    if ({1'b0, col_cur} + (COL_W+1)'(1) >= {1'b0, src_width}) begin
      col_pos_next = '0;
      if ({1'b0, row_cur} + (ROW_W+1)'(1) >= {1'b0, src_height}) begin
        row_pos_next = '0;
      end else begin
        row_pos_next = row_cur + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Screen position of the first span
  assign x0     = centre_offset(PW'(SCREEN_WIDTH), PW'(src_width));
  assign y0     = centre_offset(PW'(SCREEN_HEIGHT), PW'(src_height));
  assign x_full = x0 + $signed(PW'(col_cur) * PW'(SCALE));
  assign y_full = y0 + $signed(PW'(row_cur) * PW'(SCALE));

  // Hold the positioned pixel until the emitter takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (accept) begin
      item.valid <= 1'b1;
    end else if (take) begin
      item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.opaque <= opaque;
      item.x      <= x_full[X_W-1:0];
      item.y      <= y_full[Y_W-1:0];
      item.color  <= color;
    end
  end

endmodule

FILE: hw/rtl/msb_emit.sv
module msb_emit import msb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  item_t                     item,
  output logic                      take,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [X_W-1:0]     dest_x,
  output logic signed [Y_W-1:0]     dest_y,
  output logic        [COLOR_W-1:0] span_color,
  output logic                      last_span
);

  logic [CNT_W-1:0]     rem;
  logic signed [Y_W-1:0] act_y;
  logic                 adv;
  logic                 load;

  // Output register can take a new span
  assign adv  = !out_valid || !out_stall;
  // Start an opaque pixel once the previous one has issued all its spans
  assign load = item.valid && item.opaque && adv && (rem == '0);
  // Transparent pixels are dropped at once
  assign take = item.valid && (!item.opaque || load);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
    end else if (adv) begin
      if (rem != '0) begin
        out_valid <= 1'b1;
        rem       <= rem - CNT_W'(1);
      end else if (load) begin
        out_valid <= 1'b1;
        rem       <= CNT_W'(SCALE - 1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Issue the next span of the current pixel, or the first of a new one
  always_ff @(posedge clk) begin
    if (adv) begin
      if (rem != '0) begin
        dest_y    <= act_y;
        act_y     <= act_y + Y_W'(1);
        last_span <= (rem == CNT_W'(1));
      end else if (load) begin
        dest_x     <= item.x;
        dest_y     <= item.y;
        span_color <= item.color;
        act_y      <= item.y + Y_W'(1);
        last_span  <= (SCALE == 1);
      end
    end
  end

endmodule

FILE: hw/rtl/masked_scaled_sprite_blit.sv
// Masked sprite blit with integer upscale.
// Input channel (in_valid/in_stall): one source pixel per transaction in
// raster order, with its mask bit (opaque), colour and a frame_start flag
// that forces the position back to column 0, row 0.
// Output channel (out_valid/out_stall): one span per transaction. An opaque
// pixel yields SCALE spans on consecutive screen rows, the last one marked
// by last_span; a transparent pixel yields nothing.
// With the emitter free, an accepted pixel passes through the pixel register
// and then the span register before its first span is on the output. The
// span emitter issues one span a cycle while the receiver does not stall; a
// transparent pixel is dropped from the pixel register at once. A pixel
// register lets the next pixel be taken while the emitter is still busy.
// wr_en/wr_index/wr_data write the sprite size registers (index 0 width,
// index 1 height); write them only while the block is idle.
// Reset clears the position to column 0, row 0, sets both sizes to 48 and
// empties the pipeline. While the receiver stalls, the current span holds
// and in_stall rises once the pixel register holds an opaque pixel.
module masked_scaled_sprite_blit import msb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_index,
  input  logic [CFG_W-1:0]          wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      frame_start,
  input  logic                      opaque,
  input  logic [COLOR_W-1:0]        color,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [X_W-1:0]     dest_x,
  output logic signed [Y_W-1:0]     dest_y,
  output logic        [COLOR_W-1:0] span_color,
  output logic                      last_span
);

  item_t item;
  logic  take;

  msb_coord u_coord (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_start (frame_start),
    .opaque      (opaque),
    .color       (color),
    .take        (take),
    .item        (item)
  );

  msb_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .span_color (span_color),
    .last_span  (last_span)
  );

`ifndef SYNTHESIS
  // Stall the input only while a pixel is waiting
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item.valid)
    else $error("input stalled with no pixel waiting");

  // A span that is not the last is followed at once by another
  a_spans_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_span) |=> out_valid)
    else $error("gap inside the spans of one pixel");

  // Following spans step down one row at the same column and colour
  a_span_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_span) |=>
      (dest_x == $past(dest_x)) && (span_color == $past(span_color)) &&
      (dest_y == Y_W'($past(dest_y) + Y_W'(1))))
    else $error("span does not follow the previous row");
`endif

endmodule
